/* rtl/core/cpfe_pkg.sv */
// Package for the cone peak fitness engine: commands, field widths, request
// and result payload types and controller state encoding. No dependencies.
`default_nettype none
package cpfe_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned WidthW = 12;
  localparam int unsigned DistW = 18;
  localparam int unsigned ValW = 24;
  localparam int unsigned SumW = 42;
  localparam int unsigned CountW = 5;

  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [1:0] {
    CmdLoadCentre = 2'd0,
    CmdLoadPeak   = 2'd1,
    CmdQuery      = 2'd2,
    CmdUnused     = 2'd3
  } cmd_e;

  typedef enum logic {
    CfgPeaks = 1'b0,
    CfgDims  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        peak_index;
    logic [3:0]        dim_index;
    logic [DataW-1:0]  data_value;
    logic [WidthW-1:0] width_value;
    logic              last_coordinate;
  } req_t;

  typedef struct packed {
    logic [3:0]        result_peak;
    logic [DistW-1:0]  distance;
    logic [ValW-1:0]   cone_value;
    logic [ValW-1:0]   best_fitness;
    logic              is_last;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StAccum,
    StSqrt,
    StCone,
    StOut
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_acc;
    logic acc_en;
    logic sqrt_start;
    logic sqrt_step;
    logic cone_en;
    logic best_clr;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sqrt_done;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/cpfe_if.sv */
// Valid/ready channel interface carrying a typed payload.
// Depends on nothing; payload type is given as a type parameter.
`default_nettype none
interface cpfe_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/cpfe_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on nothing.
`default_nettype none
interface cpfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] data;
  logic       index_hi;
  modport source (output valid, output index, output index_hi, output data, input ready);
  modport sink (input valid, input index, input index_hi, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/cpfe_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cpfe_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/cpfe_ctrl.sv */
// Controller of the cone peak fitness engine: walks peaks and dimensions and
// sequences the datapath. Depends on cpfe_pkg.
`default_nettype none
module cpfe_ctrl #(
  parameter int unsigned PeakW = 4,
  parameter int unsigned DimW = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [PeakW:0]   np_i,
  input  wire logic [DimW:0]    nd_i,
  input  wire logic             out_busy_i,
  input  wire cpfe_pkg::sts_t   sts_i,
  output      cpfe_pkg::cmd_t   cmd_o,
  output      logic [PeakW-1:0] peak_o,
  output      logic [DimW-1:0]  dim_o,
  output      logic             last_peak_o,
  output      logic             busy_o
);
  cpfe_pkg::state_e state_q, state_d;
  logic [PeakW:0] peak_q, peak_d;
  logic [DimW:0]  dim_q, dim_d;
  logic dim_last, peak_last;

  assign dim_last = (dim_q + 1'b1) == nd_i;
  assign peak_last = (peak_q + 1'b1) == np_i;

  always_comb begin
    state_d = state_q;
    peak_d = peak_q;
    dim_d = dim_q;
    unique case (state_q)
      cpfe_pkg::StIdle: begin
        if (start_i) begin
          state_d = cpfe_pkg::StRead;
          peak_d = '0;
          dim_d = '0;
        end
      end
      cpfe_pkg::StRead: state_d = cpfe_pkg::StAccum;
      cpfe_pkg::StAccum: begin
        if (dim_last) begin
          state_d = cpfe_pkg::StSqrt;
        end else begin
          dim_d = dim_q + 1'b1;
          state_d = cpfe_pkg::StRead;
        end
      end
      cpfe_pkg::StSqrt: if (sts_i.sqrt_done) state_d = cpfe_pkg::StCone;
      cpfe_pkg::StCone: state_d = cpfe_pkg::StOut;
      cpfe_pkg::StOut: begin
        if (!out_busy_i) begin
          if (peak_last) begin
            state_d = cpfe_pkg::StIdle;
          end else begin
            peak_d = peak_q + 1'b1;
            dim_d = '0;
            state_d = cpfe_pkg::StRead;
          end
        end
      end
      default: state_d = cpfe_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      cpfe_pkg::StIdle: begin
        cmd_o.best_clr = start_i;
        cmd_o.clr_acc = start_i;
      end
      cpfe_pkg::StAccum: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.sqrt_start = dim_last;
      end
      cpfe_pkg::StSqrt: cmd_o.sqrt_step = 1'b1;
      cpfe_pkg::StCone: cmd_o.cone_en = 1'b1;
      cpfe_pkg::StOut: begin
        cmd_o.load_out = !out_busy_i;
        cmd_o.clr_acc = !out_busy_i;
      end
      default: cmd_o = '0;
    endcase
  end

  assign peak_o = peak_q[PeakW-1:0];
  assign dim_o = dim_q[DimW-1:0];
  assign last_peak_o = peak_last;
  assign busy_o = state_q != cpfe_pkg::StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpfe_pkg::StIdle;
      peak_q <= '0;
      dim_q <= '0;
    end else begin
      state_q <= state_d;
      peak_q <= peak_d;
      dim_q <= dim_d;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/cpfe_dp.sv */
// Datapath: tables, query point, squared-difference accumulator, bit-serial
// square root, cone arithmetic and running best. Depends on cpfe_pkg, cpfe_ram.
`default_nettype none
module cpfe_dp #(
  parameter int unsigned MaxPeaks = 16,
  parameter int unsigned MaxDims = 16,
  parameter int unsigned PeakW = 4,
  parameter int unsigned DimW = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_fire_i,
  input  wire cpfe_pkg::req_t            req_i,
  input  wire cpfe_pkg::cmd_t            cmd_i,
  input  wire logic [PeakW-1:0]          peak_i,
  input  wire logic [DimW-1:0]           dim_i,
  input  wire logic                      last_peak_i,
  output      cpfe_pkg::sts_t            sts_o,
  output      cpfe_pkg::res_t            res_o
);
  localparam int unsigned CW = $clog2(MaxPeaks * MaxDims);
  localparam int unsigned SqrtSteps = cpfe_pkg::SumW / 2;
  localparam int unsigned StepW = $clog2(SqrtSteps + 1);
  localparam int unsigned SqW = 2 * cpfe_pkg::DataW + 2;

  logic cmd_ok;
  logic pk_ok, dm_ok;
  assign pk_ok = {28'd0, req_i.peak_index} < 32'(MaxPeaks);
  assign dm_ok = {28'd0, req_i.dim_index} < 32'(MaxDims);

  logic c_we, p_we, q_we;
  assign cmd_ok = req_fire_i;
  assign c_we = cmd_ok && req_i.command == cpfe_pkg::CmdLoadCentre && pk_ok && dm_ok;
  assign p_we = cmd_ok && req_i.command == cpfe_pkg::CmdLoadPeak && pk_ok;
  assign q_we = cmd_ok && req_i.command == cpfe_pkg::CmdQuery && dm_ok;

  logic [cpfe_pkg::DataW-1:0] c_rd, q_rd, h_rd;
  logic [cpfe_pkg::WidthW-1:0] w_rd;

  cpfe_ram #(.Width(cpfe_pkg::DataW), .Depth(MaxPeaks * MaxDims)) u_centre (
    .clk_i, .we_i(c_we),
    .waddr_i(CW'(req_i.peak_index) * CW'(MaxDims) + CW'(req_i.dim_index)),
    .wdata_i(req_i.data_value),
    .raddr_i(CW'(peak_i) * CW'(MaxDims) + CW'(dim_i)),
    .rdata_o(c_rd)
  );
  cpfe_ram #(.Width(cpfe_pkg::DataW), .Depth(MaxDims)) u_query (
    .clk_i, .we_i(q_we), .waddr_i(DimW'(req_i.dim_index)), .wdata_i(req_i.data_value),
    .raddr_i(dim_i), .rdata_o(q_rd)
  );
  cpfe_ram #(.Width(cpfe_pkg::DataW), .Depth(MaxPeaks)) u_height (
    .clk_i, .we_i(p_we), .waddr_i(PeakW'(req_i.peak_index)), .wdata_i(req_i.data_value),
    .raddr_i(peak_i), .rdata_o(h_rd)
  );
  cpfe_ram #(.Width(cpfe_pkg::WidthW), .Depth(MaxPeaks)) u_width (
    .clk_i, .we_i(p_we), .waddr_i(PeakW'(req_i.peak_index)), .wdata_i(req_i.width_value),
    .raddr_i(peak_i), .rdata_o(w_rd)
  );

  // Squared difference accumulation, one dimension per pass.
  logic signed [cpfe_pkg::DataW:0] diff;
  logic [SqW-1:0] sq;
  logic [cpfe_pkg::SumW-1:0] acc_q;
  assign diff = $signed({q_rd[cpfe_pkg::DataW-1], q_rd})
              - $signed({c_rd[cpfe_pkg::DataW-1], c_rd});
  // The difference is widened before squaring so the full product is kept.
  assign sq = $unsigned(SqW'(diff) * SqW'(diff));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (cmd_i.acc_en) acc_q <= acc_q + cpfe_pkg::SumW'(sq);
  end

  // Bit-serial square root, one result bit per cycle.
  logic [cpfe_pkg::SumW-1:0] rem_q, root_q, bit_q;
  logic [StepW-1:0] step_q;
  logic [cpfe_pkg::SumW-1:0] trial;
  assign trial = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      step_q <= StepW'(SqrtSteps);
    end else if (cmd_i.sqrt_step && step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rem_q <= acc_q + cpfe_pkg::SumW'(sq);
      root_q <= '0;
      bit_q <= {2'b01, {(cpfe_pkg::SumW-2){1'b0}}};
    end else if (cmd_i.sqrt_step && step_q != '0) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end
  assign sts_o.sqrt_done = step_q == '0;

  // Cone value and running best.
  logic [cpfe_pkg::DistW-1:0] dist_sat;
  logic [cpfe_pkg::DistW+cpfe_pkg::WidthW-1:0] prod;
  logic signed [cpfe_pkg::DistW+cpfe_pkg::WidthW+1:0] val;
  logic [cpfe_pkg::ValW-1:0] val_sat, cone_q, best_q, best_n;
  logic [cpfe_pkg::DistW-1:0] dist_q;

  assign dist_sat = (root_q > cpfe_pkg::SumW'(cpfe_pkg::DistMax))
                  ? cpfe_pkg::DistMax : root_q[cpfe_pkg::DistW-1:0];
  assign prod = w_rd * dist_sat;
  assign val = $signed({{(cpfe_pkg::DistW+cpfe_pkg::WidthW+2-cpfe_pkg::DataW){h_rd[15]}}, h_rd})
             - $signed({10'd0, prod[cpfe_pkg::DistW+cpfe_pkg::WidthW-1:8]});
  always_comb begin
    if (val < $signed(-(32'sd8388608))) val_sat = cpfe_pkg::ValMin;
    else if (val > $signed(32'sd8388607)) val_sat = cpfe_pkg::ValMax;
    else val_sat = val[cpfe_pkg::ValW-1:0];
  end
  assign best_n = ($signed(cone_q) > $signed(best_q)) ? cone_q : best_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cone_en) begin
      cone_q <= val_sat;
      dist_q <= dist_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) best_q <= cpfe_pkg::ValMin;
    else if (cmd_i.best_clr) best_q <= cpfe_pkg::ValMin;
    else if (cmd_i.load_out) best_q <= best_n;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_o.result_peak <= 4'(peak_i);
      res_o.distance <= dist_q;
      res_o.cone_value <= cone_q;
      res_o.best_fitness <= best_n;
      res_o.is_last <= last_peak_i;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/cone_peak_fitness_engine_top.sv */
// Cone peak fitness engine top level. Load items and non-final queries start no walk.
// A final query item starts a walk over all peaks that holds off requests until it ends:
// per peak a read and an accumulate per dimension, 21 square root steps and a done
// check, a cone step and an output step that waits while the last result is not taken.
// Reset (rst_ni low, asynchronous) sets both counts to 1 and best to minimum.
// Depends on cpfe_pkg, cpfe_if, cpfe_cfg_if, cpfe_ctrl, cpfe_dp.
`default_nettype none
module cone_peak_fitness_engine_top #(
  parameter int unsigned MaxPeaks = 16,
  parameter int unsigned MaxDims = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cpfe_cfg_if.sink  cfg,
  cpfe_if.sink      req,
  cpfe_if.source    res
);
  localparam int unsigned PeakW = (MaxPeaks > 1) ? $clog2(MaxPeaks) : 1;
  localparam int unsigned DimW = (MaxDims > 1) ? $clog2(MaxDims) : 1;

  // Configuration registers, clamped to the legal counts when used.
  logic [4:0] peaks_q, dims_q;
  logic [PeakW:0] np;
  logic [DimW:0] nd;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peaks_q <= 5'd1;
      dims_q <= 5'd1;
    end else if (cfg.valid && !cfg.index_hi) begin
      unique case (cfg.index)
        cpfe_pkg::CfgPeaks: peaks_q <= cfg.data;
        cpfe_pkg::CfgDims: dims_q <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (peaks_q == '0) np = (PeakW+1)'(1);
    else if (32'(peaks_q) > 32'(MaxPeaks)) np = (PeakW+1)'(MaxPeaks);
    else np = (PeakW+1)'(peaks_q);
    if (dims_q == '0) nd = (DimW+1)'(1);
    else if (32'(dims_q) > 32'(MaxDims)) nd = (DimW+1)'(MaxDims);
    else nd = (DimW+1)'(dims_q);
  end

  // A request is taken whenever the walk is not running.
  logic busy, fire, start;
  assign req.ready = !busy;
  assign fire = req.valid && req.ready;
  assign start = fire && req.payload.command == cpfe_pkg::CmdQuery
               && req.payload.last_coordinate;

  // Output register: holds one result until the consumer takes it.
  logic out_valid_q, out_busy;
  cpfe_pkg::cmd_t cmd;
  cpfe_pkg::sts_t sts;
  logic [PeakW-1:0] peak;
  logic [DimW-1:0] dim;
  logic last_peak;

  assign out_busy = out_valid_q && !res.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.load_out) out_valid_q <= 1'b1;
    else if (res.ready) out_valid_q <= 1'b0;
  end
  assign res.valid = out_valid_q;

  cpfe_ctrl #(.PeakW(PeakW), .DimW(DimW)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .np_i(np), .nd_i(nd),
    .out_busy_i(out_busy), .sts_i(sts), .cmd_o(cmd), .peak_o(peak),
    .dim_o(dim), .last_peak_o(last_peak), .busy_o(busy)
  );

  cpfe_dp #(.MaxPeaks(MaxPeaks), .MaxDims(MaxDims), .PeakW(PeakW), .DimW(DimW)) u_dp (
    .clk_i, .rst_ni, .req_fire_i(fire), .req_i(req.payload), .cmd_i(cmd),
    .peak_i(peak), .dim_i(dim), .last_peak_i(last_peak), .sts_o(sts),
    .res_o(res.payload)
  );
endmodule
`default_nettype wire
